FILE: rtl/dtq_pkg.sv
package dtq_pkg;

	localparam int MAX_FRAC_DIGITS_DEF = 12;
	localparam int FCNT_W = 5;
	localparam int EXP_W = 9;
	localparam int WIDE_W = 256;
	localparam int CNT_W = 7;
	localparam int QUO_W = 64;
	localparam logic [EXP_W-1:0] EXP_DIGIT_LIMIT = 9'd40;
	localparam logic [EXP_W-1:0] EXP_FAIL_LIMIT = 9'd20;

	typedef enum logic [2:0] {
		PH_START, PH_INT, PH_FRAC, PH_EXP_START, PH_EXP_DIGITS, PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MULF, ST_ADDF, ST_MULE, ST_SAT, ST_DIV, ST_FIN
	} state_t;

	typedef struct packed {
		logic              neg;
		logic [63:0]       int_acc;
		logic [63:0]       frac_acc;
		logic [FCNT_W-1:0] frac_cnt;
		logic              seen;
		logic [EXP_W-1:0]  exp_acc;
		logic              exp_neg;
	} tok_t;

	typedef struct packed {
		logic load;
		logic mul_num;
		logic mul_den;
		logic add_frac;
		logic sat_load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic              fail;
		logic [FCNT_W-1:0] frac_cnt;
		logic [EXP_W-1:0]  exp_acc;
		logic              exp_neg;
	} stat_t;

endpackage

FILE: rtl/dtq_parser.sv
module dtq_parser import dtq_pkg::*; #(
	parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output tok_t       tok_next
);

	phase_t phase_q, phase_d;
	tok_t   tok_q, tok_d;
	logic   dig, sign, emark;
	logic [3:0] d;

	assign dig   = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign d     = char_code[3:0];
	assign sign  = (char_code == 8'h2B) || (char_code == 8'h2D);
	assign emark = (char_code == 8'h65) || (char_code == 8'h45);

	always_comb begin
		tok_d   = tok_q;
		phase_d = phase_q;
		unique case (phase_q)
			PH_START, PH_INT: begin
				if (phase_q == PH_START && sign) begin
					tok_d.neg = (char_code == 8'h2D);
					phase_d = PH_INT;
				end else if (dig) begin
					tok_d.int_acc = (tok_q.int_acc << 3) + (tok_q.int_acc << 1) + {60'd0, d};
					tok_d.seen = 1'b1;
					phase_d = PH_INT;
				end else if (char_code == 8'h2E) begin
					phase_d = PH_FRAC;
				end else if (emark) begin
					phase_d = PH_EXP_START;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_FRAC: begin
				if (dig) begin
					if (tok_q.frac_cnt < FCNT_W'(MAX_FRAC_DIGITS)) begin
						tok_d.frac_acc = (tok_q.frac_acc << 3) + (tok_q.frac_acc << 1)
							+ {60'd0, d};
						tok_d.frac_cnt = tok_q.frac_cnt + 1'b1;
						tok_d.seen = 1'b1;
					end
				end else if (emark) begin
					phase_d = PH_EXP_START;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_EXP_START: begin
				if (sign) begin
					tok_d.exp_neg = (char_code == 8'h2D);
					phase_d = PH_EXP_DIGITS;
				end else if (dig) begin
					tok_d.exp_acc = {5'd0, d};
					phase_d = PH_EXP_DIGITS;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_EXP_DIGITS: begin
				if (dig && tok_q.exp_acc < EXP_DIGIT_LIMIT)
					tok_d.exp_acc = (tok_q.exp_acc << 3) + (tok_q.exp_acc << 1) + {5'd0, d};
				else
					phase_d = PH_DONE;
			end
			default: ;
		endcase
	end

	assign tok_next = tok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			tok_q   <= '0;
		end else if (fire) begin
			// clear for the next token after the closing character
			if (last_char) begin
				phase_q <= PH_START;
				tok_q   <= '0;
			end else begin
				phase_q <= phase_d;
				tok_q   <= tok_d;
			end
		end
	end

endmodule

FILE: rtl/dtq_datapath.sv
module dtq_datapath import dtq_pkg::*; (
	input  logic        clk,
	input  tok_t        tok,
	input  cmd_t        cmd,
	output stat_t       st,
	output logic [63:0] value_fixed,
	output logic        ok
);

	logic [WIDE_W-1:0] num_q, den_q, rem_q, rem2, diff;
	logic [63:0]       low_q, frac_q, mag;
	logic [QUO_W-1:0]  quo_q;
	logic              neg_q, sat_q, ge;
	stat_t             st_q;

	assign st   = st_q;
	assign rem2 = {rem_q[WIDE_W-2:0], low_q[63]};
	assign diff = rem2 - den_q;
	assign ge   = rem2 >= den_q;
	assign mag  = sat_q ? 64'h7FFF_FFFF_FFFF_FFFF : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q       <= {192'd0, tok.int_acc};
			den_q       <= WIDE_W'(1);
			frac_q      <= tok.frac_acc;
			neg_q       <= tok.neg;
			st_q.fail   <= !tok.seen || (tok.exp_acc >= EXP_FAIL_LIMIT);
			st_q.frac_cnt <= tok.frac_cnt;
			st_q.exp_acc  <= tok.exp_acc;
			st_q.exp_neg  <= tok.exp_neg;
		end
		if (cmd.mul_num) num_q <= (num_q << 3) + (num_q << 1);
		if (cmd.mul_den) den_q <= (den_q << 3) + (den_q << 1);
		if (cmd.add_frac) num_q <= num_q + {192'd0, frac_q};
		if (cmd.sat_load) begin
			// quotient below 2^63 keeps the upper dividend below the divisor
			sat_q <= num_q >= (den_q << 31);
			rem_q <= {32'd0, num_q[WIDE_W-1:32]};
			low_q <= {num_q[31:0], 32'd0};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff : rem2;
			low_q <= {low_q[62:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
		if (cmd.out_load) begin
			ok          <= !st_q.fail;
			value_fixed <= st_q.fail ? 64'd0 : (neg_q ? (~mag + 64'd1) : mag);
		end
	end

endmodule

FILE: rtl/dtq_ctrl.sv
module dtq_ctrl import dtq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  last_char,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  tok_t  tok,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && last_char) begin
					cmd.load = 1'b1;
					cnt_d = '0;
					if (!tok.seen || tok.exp_acc >= EXP_FAIL_LIMIT) state_d = ST_FIN;
					else state_d = ST_MULF;
				end
			end
			ST_MULF: begin
				if (cnt_q == {2'b00, st.frac_cnt}) begin
					state_d = ST_ADDF;
				end else begin
					cmd.mul_num = 1'b1;
					cmd.mul_den = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ADDF: begin
				cmd.add_frac = 1'b1;
				cnt_d = '0;
				state_d = ST_MULE;
			end
			ST_MULE: begin
				if (cnt_q == CNT_W'(st.exp_acc)) begin
					state_d = ST_SAT;
				end else begin
					cmd.mul_den = st.exp_neg;
					cmd.mul_num = !st.exp_neg;
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SAT: begin
				cmd.sat_load = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register frees up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q) else $error("result dropped");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(QUO_W)) else $error("divide overrun");
	a_load_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == ST_IDLE && out_valid_q) else $error("load lost");

endmodule

FILE: rtl/decimal_text_to_q32_32_top.sv
// Decimal text to signed Q32.32 converter.
// Input channel (in_valid/in_ready): one ASCII character per transaction,
// last_char marks the end of a token. Output channel (out_valid/out_ready):
// one transaction per token carrying value_fixed and ok.
// Characters are taken one per cycle while the block is idle. The closing
// character starts the finish sequence: a load, one step per kept fraction
// digit plus one to leave that loop, the fraction add, one step per unit of
// |exponent| plus one to leave that loop, a saturation check, the bit-serial
// restoring divider, which yields one quotient bit per cycle for a 64-bit
// quotient, and the output register load. A failed token skips straight to
// the output load. No character is taken during the sequence.
// The result waits in an output register; while the receiver stalls, the
// next token is still taken and finished, but its sequence holds in the
// output load cycle, with in_ready low, until the previous result is taken.
// Reset clears the parser to the start of a token and empties the output.
module decimal_text_to_q32_32_top import dtq_pkg::*; #(
	parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value_fixed,
	output logic        ok
);

	tok_t  tok;
	cmd_t  cmd;
	stat_t st;

	dtq_parser #(.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_parser (
		.clk(clk), .arst_n(arst_n), .fire(in_valid && in_ready),
		.char_code(char_code), .last_char(last_char), .tok_next(tok)
	);

	dtq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last_char(last_char),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.tok(tok), .st(st), .cmd(cmd)
	);

	dtq_datapath u_dp (
		.clk(clk), .tok(tok), .cmd(cmd), .st(st),
		.value_fixed(value_fixed), .ok(ok)
	);

endmodule
